@@ rtl/pal_pkg.sv @@
// ----------------------------------------------------------------------------
// pal_pkg
// Types and constants shared by the positional array list and its cells.
// ----------------------------------------------------------------------------
package pal_pkg;

   localparam int CAPACITY   = 128;
   localparam int DATA_WIDTH = 32;

   localparam int OP_W    = 3;
   localparam int POS_W   = 8;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 8;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT_HEAD = 3'd0,
      OP_INSERT_TAIL = 3'd1,
      OP_INSERT_AT   = 3'd2,
      OP_REMOVE_HEAD = 3'd3,
      OP_REMOVE_TAIL = 3'd4,
      OP_REMOVE_AT   = 3'd5
   } op_type;

   typedef logic [DATA_WIDTH-1:0] word_type;
   typedef logic [CMP_W-1:0]      index_type;

   typedef struct packed {
      logic      insert;
      logic      remove;
      index_type position;
      word_type  value;
   } cell_ctl_type;

endpackage

@@ rtl/pal_cell.sv @@
// ----------------------------------------------------------------------------
// pal_cell
// One list slot. On an insert it takes the word from the slot below or the
// new word; on a removal it takes the word from the slot above.
// ----------------------------------------------------------------------------
module pal_cell
   import pal_pkg::*;
(
   input  logic         clock,
   input  index_type    cell_index,
   input  cell_ctl_type ctl,
   input  word_type     lower_entry,
   input  word_type     upper_entry,
   output word_type     entry,
   output word_type     tap
);

   word_type entry_ff;
   word_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert) begin
         if (cell_index > ctl.position) begin
            entry_in = lower_entry;
         end else if (cell_index == ctl.position) begin
            entry_in = ctl.value;
         end
      end else if (ctl.remove && (cell_index >= ctl.position)) begin
         entry_in = upper_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign tap   = (cell_index == ctl.position) ? entry_ff : '0;

endmodule

@@ rtl/positional_array_list_unit.sv @@
// ----------------------------------------------------------------------------
// positional_array_list_unit
// Bounded ordered list of words with insert and remove at head, tail or a
// given position, built as a row of slot cells that all shift together.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  request   start / busy     req_op, req_position, req_value
//  response  rsp_valid        rsp_ok, rsp_removed_value, rsp_count_after
//
//  Every request is finished in the cycle of its transfer; all slots shift
//  together, so a new request is taken on every clock and busy stays low.
//  The response appears in the cycle after the request transfer, for one cycle.
//  Reset empties the list at once; slot contents are not cleared.
//  The response receiver cannot stall the block.
// ----------------------------------------------------------------------------
module positional_array_list_unit
   import pal_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [OP_W-1:0]    req_op,
   input  logic [POS_W-1:0]   req_position,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   output logic               rsp_ok,
   output logic [VALUE_W-1:0] rsp_removed_value,
   output logic [COUNT_W-1:0] rsp_count_after
);

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               rsp_valid_ff;
   logic               rsp_ok_ff;
   logic               rsp_ok_in;
   logic [VALUE_W-1:0] removed_ff;
   logic [VALUE_W-1:0] removed_in;
   logic [COUNT_W-1:0] count_after_ff;

   logic         accept;
   logic         is_insert;
   logic         is_remove;
   index_type    target;
   index_type    count_ext;
   cell_ctl_type ctl;
   word_type     entries [CAPACITY];
   word_type     taps    [CAPACITY];
   word_type     picked;

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign count_ext = CMP_W'(count_ff);

   always_comb begin
      is_insert = 1'b0;
      is_remove = 1'b0;
      target    = '0;
      unique case (req_op)
         OP_INSERT_HEAD: begin
            is_insert = 1'b1;
         end
         OP_INSERT_TAIL: begin
            is_insert = 1'b1;
            target    = count_ext;
         end
         OP_INSERT_AT: begin
            is_insert = 1'b1;
            target    = CMP_W'(req_position);
         end
         OP_REMOVE_HEAD: begin
            is_remove = 1'b1;
         end
         OP_REMOVE_TAIL: begin
            is_remove = 1'b1;
            target    = count_ext - CMP_W'(1);
         end
         OP_REMOVE_AT: begin
            is_remove = 1'b1;
            target    = CMP_W'(req_position);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      ctl.insert   = accept && is_insert && (count_ext < CMP_W'(CAPACITY))
                     && (target <= count_ext);
      ctl.remove   = accept && is_remove && (count_ff != '0) && (target < count_ext);
      ctl.position = target;
      ctl.value    = DATA_WIDTH'(req_value);
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      word_type lower;
      word_type upper;
      if (i == 0) begin : g_first
         assign lower = '0;
      end else begin : g_lower
         assign lower = entries[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign upper = '0;
      end else begin : g_upper
         assign upper = entries[i+1];
      end
      pal_cell u_cell (
         .clock       (clock),
         .cell_index  (CMP_W'(i)),
         .ctl         (ctl),
         .lower_entry (lower),
         .upper_entry (upper),
         .entry       (entries[i]),
         .tap         (taps[i])
      );
   end

   always_comb begin
      picked = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         picked = picked | taps[i];
      end
   end

   always_comb begin
      count_in   = count_ff;
      rsp_ok_in  = ctl.insert || ctl.remove;
      removed_in = '0;
      if (ctl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.remove) begin
         count_in   = count_ff - CNT_W'(1);
         removed_in = VALUE_W'(picked);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff      <= rsp_ok_in;
      removed_ff     <= removed_in;
      count_after_ff <= COUNT_W'(count_in);
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_count_after   = count_after_ff;

   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("Accepted request produced no response.");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid)
      else $error("Response without a request.");

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count_after == COUNT_W'(count_ff)))
      else $error("Reported count differs from held count.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("Entry count exceeds capacity.");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_removed_value == '0))
      else $error("Rejected request returned a word.");

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the positional array list: directed corner requests,
// then insert-heavy, remove-heavy and mixed random phases sent in bursts with
// random gaps, each response checked against a list predictor in the bench.
// ----------------------------------------------------------------------------
module tb;
   import pal_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;
   localparam int RANDOM_REQUESTS = 1450;

   typedef struct {
      logic [OP_W-1:0]    op;
      logic [POS_W-1:0]   position;
      logic [VALUE_W-1:0] value;
   } list_request_type;

   typedef struct {
      logic               ok;
      logic [VALUE_W-1:0] removed_value;
      logic [COUNT_W-1:0] count_after;
   } list_reply_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [OP_W-1:0]    req_op = '0;
   logic [POS_W-1:0]   req_position = '0;
   logic [VALUE_W-1:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ok;
   logic [VALUE_W-1:0] rsp_removed_value;
   logic [COUNT_W-1:0] rsp_count_after;

   list_request_type request_backlog[$];
   list_reply_type   awaited_replies[$];
   word_type         list_words[CAPACITY];
   int               list_count = 0;
   int               planned_count = 0;
   int               burst_left = 1;
   int               gap_left = 0;
   int               failures = 0;

   positional_array_list_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ok            (rsp_ok),
      .rsp_removed_value (rsp_removed_value),
      .rsp_count_after   (rsp_count_after)
   );

   always #5 clock = ~clock;

   task automatic model_list_request(input logic [OP_W-1:0] op,
                                     input logic [POS_W-1:0] position,
                                     input logic [VALUE_W-1:0] value);
      list_reply_type reply;
      int             at;
      logic           is_insert;
      logic           is_remove;
      reply = '{1'b0, '0, '0};
      at = int'(position);
      is_insert = 1'b0;
      is_remove = 1'b0;
      case (op)
         OP_INSERT_HEAD: begin at = 0; is_insert = 1'b1; end
         OP_INSERT_TAIL: begin at = list_count; is_insert = 1'b1; end
         OP_INSERT_AT: is_insert = 1'b1;
         OP_REMOVE_HEAD: begin at = 0; is_remove = 1'b1; end
         OP_REMOVE_TAIL: begin at = list_count - 1; is_remove = 1'b1; end
         OP_REMOVE_AT: is_remove = 1'b1;
         default: ;
      endcase
      if (is_insert && list_count < CAPACITY && at <= list_count) begin
         for (int i = list_count; i > at; i--)
            list_words[i] = list_words[i-1];
         list_words[at] = value[DATA_WIDTH-1:0];
         list_count++;
         reply.ok = 1'b1;
      end
      if (is_remove && list_count > 0 && at >= 0 && at < list_count) begin
         reply.removed_value = VALUE_W'(list_words[at]);
         for (int i = at + 1; i < list_count; i++)
            list_words[i-1] = list_words[i];
         list_count--;
         reply.ok = 1'b1;
      end
      reply.count_after = COUNT_W'(list_count);
      awaited_replies.push_back(reply);
   endtask

   // Keeps a running count so that random positions land near the live range.
   task automatic queue_request(input logic [OP_W-1:0] op,
                                input logic [POS_W-1:0] position,
                                input logic [VALUE_W-1:0] value);
      int at;
      at = int'(position);
      case (op)
         OP_INSERT_HEAD, OP_INSERT_TAIL, OP_INSERT_AT: begin
            if (op == OP_INSERT_HEAD) at = 0;
            if (op == OP_INSERT_TAIL) at = planned_count;
            if (planned_count < CAPACITY && at <= planned_count) planned_count++;
         end
         OP_REMOVE_HEAD, OP_REMOVE_TAIL, OP_REMOVE_AT: begin
            if (op == OP_REMOVE_HEAD) at = 0;
            if (op == OP_REMOVE_TAIL) at = planned_count - 1;
            if (planned_count > 0 && at >= 0 && at < planned_count) planned_count--;
         end
         default: ;
      endcase
      request_backlog.push_back('{op, position, value});
   endtask

   task automatic queue_random_request(input int insert_pct);
      logic [OP_W-1:0]    op;
      logic [POS_W-1:0]   position;
      logic [VALUE_W-1:0] value;
      int                 pick;
      position = POS_W'($urandom_range(0, 255));
      pick = $urandom_range(0, 2);
      case ($urandom_range(0, 9))
         0: value = '0;
         1: value = '1;
         default: value = $urandom;
      endcase
      if ($urandom_range(0, 99) < 2) begin
         op = ($urandom_range(0, 1) == 0) ? OP_UNUSED_LO : OP_UNUSED_HI;
      end else if ($urandom_range(0, 99) < insert_pct) begin
         op = (pick == 0) ? OP_INSERT_HEAD : (pick == 1) ? OP_INSERT_TAIL : OP_INSERT_AT;
         if (op == OP_INSERT_AT && $urandom_range(0, 99) < 85)
            position = POS_W'($urandom_range(0, planned_count));
      end else begin
         op = (pick == 0) ? OP_REMOVE_HEAD : (pick == 1) ? OP_REMOVE_TAIL : OP_REMOVE_AT;
         if (op == OP_REMOVE_AT && planned_count > 0 && $urandom_range(0, 99) < 85)
            position = POS_W'($urandom_range(0, planned_count - 1));
      end
      queue_request(op, position, value);
   endtask

   always @(posedge clock) begin : drive_requests
      list_request_type item;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            model_list_request(req_op, req_position, req_value);
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (request_backlog.size() > 0) begin
               item = request_backlog.pop_front();
               req_op <= item.op;
               req_position <= item.position;
               req_value <= item.value;
               start <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_replies
      list_reply_type want;
      if (!reset && rsp_valid) begin
         if (awaited_replies.size() == 0) begin
            $display("%0t: response with none expected: ok %0d removed %h count %0d",
                     $time, rsp_ok, rsp_removed_value, rsp_count_after);
            failures++;
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_ok !== want.ok) begin
               $display("%0t: ok expected %0d actual %0d", $time, want.ok, rsp_ok);
               failures++;
            end
            if (rsp_removed_value !== want.removed_value) begin
               $display("%0t: removed_value expected %h actual %h",
                        $time, want.removed_value, rsp_removed_value);
               failures++;
            end
            if (rsp_count_after !== want.count_after) begin
               $display("%0t: count_after expected %0d actual %0d",
                        $time, want.count_after, rsp_count_after);
               failures++;
            end
         end
      end
   end

   initial begin
      int phase;
      int phase_len;
      int insert_pct;
      int issued;
      queue_request(OP_REMOVE_HEAD, 8'd0, 32'h0);
      queue_request(OP_REMOVE_TAIL, 8'd255, 32'hFFFF_FFFF);
      queue_request(OP_REMOVE_AT, 8'd0, 32'h0);
      queue_request(OP_INSERT_AT, 8'd1, 32'h1234_5678);
      queue_request(OP_INSERT_HEAD, 8'd0, 32'h0000_0000);
      queue_request(OP_INSERT_TAIL, 8'd255, 32'hFFFF_FFFF);
      queue_request(OP_INSERT_AT, 8'd2, 32'hA5A5_A5A5);
      queue_request(OP_INSERT_AT, 8'd1, 32'h5A5A_5A5A);
      queue_request(OP_INSERT_AT, 8'd255, 32'hDEAD_BEEF);
      queue_request(OP_INSERT_AT, 8'd128, 32'hCAFE_F00D);
      queue_request(OP_UNUSED_LO, 8'd255, 32'hFFFF_FFFF);
      queue_request(OP_UNUSED_HI, 8'd0, 32'h0);
      queue_request(OP_REMOVE_AT, 8'd4, 32'h0);
      queue_request(OP_REMOVE_AT, 8'd255, 32'h0);
      queue_request(OP_REMOVE_AT, 8'd1, 32'h0);
      queue_request(OP_REMOVE_TAIL, 8'd0, 32'h0);
      queue_request(OP_REMOVE_HEAD, 8'd0, 32'h0);
      queue_request(OP_REMOVE_AT, 8'd0, 32'h0);
      queue_request(OP_REMOVE_TAIL, 8'd0, 32'h0);

      // Alternating fill, drain and mixed phases reach both the full and the empty list.
      issued = 0;
      phase = 0;
      while (issued < RANDOM_REQUESTS) begin
         phase_len = $urandom_range(120, 260);
         insert_pct = (phase % 3 == 0) ? 85 : (phase % 3 == 1) ? 15 : 50;
         for (int i = 0; i < phase_len && issued < RANDOM_REQUESTS; i++) begin
            queue_random_request(insert_pct);
            issued++;
         end
         phase++;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (request_backlog.size() != 0 || start || awaited_replies.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      if (failures == 0 && awaited_replies.size() == 0) begin
         $display("positional_array_list_unit verification clean");
      end else begin
         $display("positional_array_list_unit verification failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("positional_array_list_unit verification failed");
      $finish;
   end

endmodule
